FILE: hw/rtl/cbq_pkg.sv
`timescale 1ns / 1ps

package cbq_pkg;

  localparam int SIG_W     = 48;   // Q24.24 signal
  localparam int FRAC_W    = 24;
  localparam int COEF_W    = 32;   // Q2.30 coefficient
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam int SECTION_COUNT_DEF = 2;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int MAX_SECTIONS      = 2;

  // a 48-bit signal is multiplied in two 24-bit halves
  localparam int HALF_W  = SIG_W / 2;
  localparam int MUL_A_W = HALF_W + 1;
  localparam int PROD_W  = MUL_A_W + COEF_W;
  localparam int LOP_W   = PROD_W - HALF_W;
  localparam int TERM_W  = PROD_W - 6;
  localparam int ACC_W   = TERM_W + 3;

  localparam int NUM_TERMS = 5;
  localparam int STEP_W    = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NUM_TERMS + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEC0_B0_B1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEC0_B2_A1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEC0_A2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEC1_B0_B1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEC1_B2_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEC1_A2    = 3'd5;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  typedef struct packed {
    logic signed [SIG_W-1:0] sig;
    logic                    clip;
  } sig_item_t;

endpackage

FILE: hw/rtl/cbq_cell.sv
`timescale 1ns / 1ps

module cbq_cell import cbq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  coef_set_t coef,
  input  logic      in_valid,
  output logic      in_ready,
  input  sig_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output sig_item_t out_item
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                   state;
  logic [STEP_W-1:0]        step;
  logic signed [SIG_W-1:0]  x_cur;
  logic                     clip_in;
  logic signed [SIG_W-1:0]  x1, x2, y1, y2;
  logic signed [PROD_W-1:0] prod;
  logic signed [LOP_W-1:0]  lo_part;
  logic signed [TERM_W-1:0] term;
  logic                     term_neg;
  logic signed [ACC_W-1:0]  acc;
  sig_item_t                out_q;
  logic                     out_vld;

  logic [2:0]               term_idx;
  logic signed [SIG_W-1:0]  op;
  logic signed [COEF_W-1:0] op_coef;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [PROD_W-1:0] term_sum;
  logic                     can_finish;
  logic                     accept;
  logic                     sat_hi, sat_lo;
  logic signed [SIG_W-1:0]  y_sat;

  assign term_idx = step[3:1];

  always_comb begin
    case (term_idx)
      3'd0:    begin op = x_cur; op_coef = coef.b0; end
      3'd1:    begin op = x1;    op_coef = coef.b1; end
      3'd2:    begin op = x2;    op_coef = coef.b2; end
      3'd3:    begin op = y1;    op_coef = coef.a1; end
      3'd4:    begin op = y2;    op_coef = coef.a2; end
      default: begin op = '0;    op_coef = '0;      end
    endcase
    // low half unsigned first, then the signed high half
    if (step[0]) begin
      mul_a = {op[SIG_W-1], op[SIG_W-1:HALF_W]};
    end else begin
      mul_a = {1'b0, op[HALF_W-1:0]};
    end
  end

  // floor((hi*c*2^24 + lo*c) / 2^30) without the full 80-bit sum
  assign term_sum = prod + {{HALF_W{lo_part[LOP_W-1]}}, lo_part};

  assign sat_hi = !acc[ACC_W-1] && (acc[ACC_W-2:SIG_W-1] != '0);
  assign sat_lo = acc[ACC_W-1] && (acc[ACC_W-2:SIG_W-1] != '1);

  always_comb begin
    if (sat_hi) begin
      y_sat = {1'b0, {(SIG_W-1){1'b1}}};
    end else if (sat_lo) begin
      y_sat = {1'b1, {(SIG_W-1){1'b0}}};
    end else begin
      y_sat = acc[SIG_W-1:0];
    end
  end

  assign can_finish = !out_vld || out_ready;
  assign in_ready   = (state == ST_IDLE) || (state == ST_DONE && can_finish);
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    prod <= mul_a * op_coef;
    if (state == ST_RUN && step[0]) begin
      lo_part <= prod[PROD_W-1:HALF_W];
    end
    if (state == ST_RUN && !step[0]) begin
      term     <= term_sum[PROD_W-1:6];
      term_neg <= (step == STEP_W'(8)) || (step == STEP_W'(10));
    end
    if (accept) begin
      x_cur   <= in_item.sig;
      clip_in <= in_item.clip;
      acc     <= '0;
    end else if (state == ST_RUN && step[0] && step >= STEP_W'(3)) begin
      if (term_neg) begin
        acc <= acc - {{3{term[TERM_W-1]}}, term};
      end else begin
        acc <= acc + {{3{term[TERM_W-1]}}, term};
      end
    end

    if (rst) begin
      state   <= ST_IDLE;
      step    <= '0;
      x1      <= '0;
      x2      <= '0;
      y1      <= '0;
      y2      <= '0;
      out_vld <= 1'b0;
    end else begin
      if (state == ST_DONE && can_finish) begin
        out_vld <= 1'b1;
      end else if (out_vld && out_ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_finish) begin
            x2      <= x1;
            x1      <= x_cur;
            y2      <= y1;
            y1      <= y_sat;
            out_q   <= '{sig: y_sat, clip: clip_in | sat_hi | sat_lo};
            state   <= accept ? ST_RUN : ST_IDLE;
            step    <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_vld;
  assign out_item  = out_q;

endmodule

FILE: hw/rtl/cbq_out.sv
`timescale 1ns / 1ps

module cbq_out import cbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sig_item_t                     in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  localparam int RND_W = SIG_W - FRAC_W + 1;

  logic signed [SIG_W:0]     rnd_sum;
  logic signed [RND_W-1:0]   rnd;
  logic                      ovf_hi, ovf_lo;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic                      vld;

  // round half up then floor shift
  assign rnd_sum = {in_item.sig[SIG_W-1], in_item.sig} + (SIG_W+1)'(1 << (FRAC_W - 1));
  assign rnd     = rnd_sum[SIG_W:FRAC_W];
  assign ovf_hi  = !rnd[RND_W-1] && (rnd[RND_W-2:SAMPLE_BITS-1] != '0);
  assign ovf_lo  = rnd[RND_W-1] && (rnd[RND_W-2:SAMPLE_BITS-1] != '1);

  always_comb begin
    if (ovf_hi) begin
      sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (ovf_lo) begin
      sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_val = rnd[SAMPLE_BITS-1:0];
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_out <= sat_val;
      clipped    <= in_item.clip | ovf_hi | ovf_lo;
    end
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

endmodule

FILE: hw/rtl/cascaded_biquad_iir_filter.sv
`timescale 1ns / 1ps
// channel  | handshake          | payload
// input    | in_valid/in_ready  | sample_in
// output   | out_valid/out_ready| sample_out, clipped
// config   | cfg_wr_en          | cfg_index, cfg_data
//
// one cell per section; each cell runs its five terms through one 25x32
// multiplier, two halves per term, taking a new item only as its last one leaves
// cells overlap on successive items, each section busy with a different one
// path to out_valid: each section's output register, then the rounding register
// rst clears coefficients, filter history and all valid flags
// a full output register stalls the last cell, which then holds off its neighbor

module cascaded_biquad_iir_filter import cbq_pkg::*; #(
  parameter int SECTION_COUNT = SECTION_COUNT_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  coef_set_t sec_coef [0:MAX_SECTIONS-1];

  logic      chain_vld  [0:SECTION_COUNT];
  logic      chain_rdy  [0:SECTION_COUNT];
  sig_item_t chain_item [0:SECTION_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_coef[0] <= '0;
      sec_coef[1] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SEC0_B0_B1: begin
          sec_coef[0].b0 <= cfg_data[31:0];
          sec_coef[0].b1 <= cfg_data[63:32];
        end
        REG_SEC0_B2_A1: begin
          sec_coef[0].b2 <= cfg_data[31:0];
          sec_coef[0].a1 <= cfg_data[63:32];
        end
        REG_SEC0_A2: sec_coef[0].a2 <= cfg_data[31:0];
        REG_SEC1_B0_B1: begin
          sec_coef[1].b0 <= cfg_data[31:0];
          sec_coef[1].b1 <= cfg_data[63:32];
        end
        REG_SEC1_B2_A1: begin
          sec_coef[1].b2 <= cfg_data[31:0];
          sec_coef[1].a1 <= cfg_data[63:32];
        end
        REG_SEC1_A2: sec_coef[1].a2 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // sample enters as sample * 2^24
  assign chain_vld[0]  = in_valid;
  assign in_ready      = chain_rdy[0];
  assign chain_item[0] = '{sig: SIG_W'(sample_in) << FRAC_W, clip: 1'b0};

  for (genvar s = 0; s < SECTION_COUNT; s++) begin : g_sec
    cbq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef      (sec_coef[s]),
      .in_valid  (chain_vld[s]),
      .in_ready  (chain_rdy[s]),
      .in_item   (chain_item[s]),
      .out_valid (chain_vld[s+1]),
      .out_ready (chain_rdy[s+1]),
      .out_item  (chain_item[s+1])
    );
  end

  cbq_out #(.SAMPLE_BITS(SAMPLE_BITS)) u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_vld[SECTION_COUNT]),
    .in_ready   (chain_rdy[SECTION_COUNT]),
    .in_item    (chain_item[SECTION_COUNT]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

endmodule

FILE: hw/rtl/cbq_checker.sv
`timescale 1ns / 1ps

module cbq_checker import cbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          clipped
);

  logic [3:0] in_flight;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_first_cell_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while the first section is busy");

  a_no_invented_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != 4'd0)
    else $error("result shown with no item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("stalled result changed");

endmodule

bind cascaded_biquad_iir_filter cbq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cbq_checker (.*);

FILE: test/cascaded_biquad_iir_filter_test.sv
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter_test;
  import cbq_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int SMP_W        = SAMPLE_BITS_DEF;
  localparam int REG_COUNT    = 6;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_AT      = 1600;
  localparam int HOLD_CYCLES  = 400;
  localparam int TIMEOUT_NS   = 2_000_000;

  // the index field reaches past the last register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [COEF_W-1:0] Q30_ZERO = 32'h0000_0000;
  localparam logic [COEF_W-1:0] Q30_ONE  = 32'h4000_0000;
  localparam logic [COEF_W-1:0] Q30_HALF = 32'h2000_0000;
  localparam logic [COEF_W-1:0] Q30_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] Q30_MIN  = 32'h8000_0000;
  localparam int unsigned TINY_SPAN = 32'h1000_0000;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
  localparam longint SIG_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SIG_LO = -SIG_HI - 1;
  localparam longint OUT_HI = (64'sd1 <<< (SMP_W - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp_val;
    logic                    clip;
  } filt_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_W-1:0]        data;
    logic signed [SMP_W-1:0] smp;
    logic                    typed;
    filt_result_t            res;
  } script_row_t;

  typedef enum logic [2:0] {
    SET_LOWPASS, SET_HIGHPASS, SET_BANDPASS, SET_RANDOM, SET_TINY, SET_ALL_MAX, SET_ALL_MIN
  } setting_t;

  localparam filt_result_t ZERO_RES = '{16'sd0, 1'b0};

  localparam script_row_t SCRIPT [30] = '{
    // coefficients all zero after reset
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MAX, 1'b1, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MIN, 1'b1, ZERO_RES},
    // writes past the last register are dropped
    '{ROW_WRITE, REG_SPARE_6, {64{1'b1}}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, REG_SPARE_7, {64{1'b1}}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, 16'sd1, 1'b1, ZERO_RES},
    // unity gain through both sections
    '{ROW_WRITE, REG_SEC0_B0_B1, {Q30_ZERO, Q30_ONE}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, REG_SEC1_B0_B1, {Q30_ZERO, Q30_ONE}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MAX, 1'b1, '{SMP_MAX, 1'b0}},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MIN, 1'b1, '{SMP_MIN, 1'b0}},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, 16'sd0, 1'b1, ZERO_RES},
    // half gain: output rounds half up
    '{ROW_WRITE, REG_SEC0_B0_B1, {Q30_ZERO, Q30_HALF}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, 16'sd1, 1'b1, '{16'sd1, 1'b0}},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, -16'sd1, 1'b1, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, 16'sd3, 1'b1, '{16'sd2, 1'b0}},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, -16'sd3, 1'b1, '{-16'sd1, 1'b0}},
    // gain close to four: output saturates
    '{ROW_WRITE, REG_SEC0_B0_B1, {Q30_ZERO, Q30_MAX}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, REG_SEC1_B0_B1, {Q30_ZERO, Q30_MAX}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MAX, 1'b1, '{SMP_MAX, 1'b1}},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MIN, 1'b1, '{SMP_MIN, 1'b1}},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, 16'sd8191, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, -16'sd8192, 1'b0, ZERO_RES},
    // strong feedback drives the sections into saturation
    '{ROW_WRITE, REG_SEC0_B2_A1, {Q30_MIN, Q30_ZERO}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, REG_SEC0_A2, {32'hFFFF_FFFF, Q30_MIN}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, REG_SEC1_B2_A1, {Q30_MAX, Q30_MAX}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, REG_SEC1_A2, {32'hFFFF_FFFF, 32'hC000_0000}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MAX, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MAX, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, SMP_MIN, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, 16'sd100, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, REG_SEC0_B0_B1, 64'd0, -16'sd100, 1'b0, ZERO_RES}
  };

  localparam setting_t PHASE_PLAN [PHASES] = '{
    SET_LOWPASS, SET_RANDOM, SET_BANDPASS, SET_ALL_MAX,
    SET_TINY, SET_ALL_MIN, SET_HIGHPASS, SET_RANDOM
  };

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SMP_W-1:0] sample_in;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SMP_W-1:0] sample_out;
  logic                    clipped;

  // typed expectation travels with the sample it belongs to
  logic         tag_typed;
  filt_result_t tag_res;

  int send_idle_pct = 8;
  int recv_idle_pct = 76;
  int samples_accepted = 0;
  int outputs_seen = 0;
  int mismatch_count = 0;

  logic [CFG_W-1:0] coef_bank [REG_COUNT];
  longint           x_hist [2*MAX_SECTIONS];
  longint           y_hist [2*MAX_SECTIONS];
  filt_result_t     pending_outputs [$];

  cascaded_biquad_iir_filter u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // floor(sig * coef / 2^30), exact
  function automatic longint q30_term(input longint sig, input logic signed [COEF_W-1:0] coef);
    logic signed [79:0] prod;
    prod = sig * coef;
    return 64'(prod >>> 30);
  endfunction

  function automatic filt_result_t run_cascade(input logic signed [SMP_W-1:0] smp);
    coef_set_t    c;
    longint       sig;
    longint       acc;
    longint       r;
    filt_result_t res;
    sig = longint'(smp) * 64'sd16777216;
    res.clip = 1'b0;
    for (int s = 0; s < SECTION_COUNT_DEF; s++) begin
      c.b0 = coef_bank[3*s][31:0];
      c.b1 = coef_bank[3*s][63:32];
      c.b2 = coef_bank[3*s+1][31:0];
      c.a1 = coef_bank[3*s+1][63:32];
      c.a2 = coef_bank[3*s+2][31:0];
      acc = q30_term(sig, c.b0) + q30_term(x_hist[2*s], c.b1)
          + q30_term(x_hist[2*s+1], c.b2) - q30_term(y_hist[2*s], c.a1)
          - q30_term(y_hist[2*s+1], c.a2);
      if (acc > SIG_HI) begin
        acc = SIG_HI;
        res.clip = 1'b1;
      end else if (acc < SIG_LO) begin
        acc = SIG_LO;
        res.clip = 1'b1;
      end
      x_hist[2*s+1] = x_hist[2*s];
      x_hist[2*s]   = sig;
      y_hist[2*s+1] = y_hist[2*s];
      y_hist[2*s]   = acc;
      sig = acc;
    end
    r = (sig + 64'sd8388608) >>> 24;
    if (r > OUT_HI) begin
      r = OUT_HI;
      res.clip = 1'b1;
    end else if (r < OUT_LO) begin
      r = OUT_LO;
      res.clip = 1'b1;
    end
    res.smp_val = r[SMP_W-1:0];
    return res;
  endfunction

  // model of the block, updated on every handshake and configuration write
  always @(posedge clk) begin
    filt_result_t want;
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) coef_bank[i] = '0;
      for (int i = 0; i < 2*MAX_SECTIONS; i++) begin
        x_hist[i] = 0;
        y_hist[i] = 0;
      end
      pending_outputs.delete();
    end else begin
      if (cfg_wr_en && cfg_index < REG_COUNT) begin
        if (cfg_index == REG_SEC0_A2 || cfg_index == REG_SEC1_A2)
          coef_bank[cfg_index] = {32'h0, cfg_data[31:0]};
        else
          coef_bank[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        want = run_cascade(sample_in);
        if (tag_typed) want = tag_res;
        pending_outputs.push_back(want);
      end
      if (out_valid && out_ready) begin
        outputs_seen++;
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected item sample_out %0d clipped %0b",
                   $time, sample_out, clipped);
          mismatch_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (sample_out !== want.smp_val) begin
            $display("%0t: sample_out expected %0d got %0d", $time, want.smp_val, sample_out);
            mismatch_count++;
          end
          if (clipped !== want.clip) begin
            $display("%0t: clipped expected %0b got %0b", $time, want.clip, clipped);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int  taken;
    int  hold_left;
    bit  held;
    taken = 0;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!held && taken >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic offer(input logic signed [SMP_W-1:0] smp, input logic typed,
                       input filt_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    tag_typed <= typed;
    tag_res   <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_accepted++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (outputs_seen != samples_accepted) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] to_q30(input real r);
    return $rtoi(r * 1073741824.0);
  endfunction

  // second-order butterworth, cutoff at a tenth of the sample rate
  function automatic coef_set_t butterworth(input bit highpass);
    coef_set_t c;
    c.a1 = to_q30(-1.1429805);
    c.a2 = to_q30(0.4128016);
    if (highpass) begin
      c.b0 = to_q30(0.6389455);
      c.b1 = to_q30(-1.2778910);
      c.b2 = to_q30(0.6389455);
    end else begin
      c.b0 = to_q30(0.0674553);
      c.b1 = to_q30(0.1349105);
      c.b2 = to_q30(0.0674553);
    end
    return c;
  endfunction

  task automatic load_setting(input setting_t kind);
    coef_set_t sec [2];
    for (int s = 0; s < 2; s++) begin
      case (kind)
        SET_LOWPASS:  sec[s] = butterworth(1'b0);
        SET_HIGHPASS: sec[s] = butterworth(1'b1);
        SET_BANDPASS: sec[s] = butterworth(s == 0);
        SET_ALL_MAX:  sec[s] = {5{Q30_MAX}};
        SET_ALL_MIN:  sec[s] = {5{Q30_MIN}};
        SET_TINY: begin
          sec[s].b0 = $urandom_range(TINY_SPAN) - TINY_SPAN / 2;
          sec[s].b1 = $urandom_range(TINY_SPAN) - TINY_SPAN / 2;
          sec[s].b2 = $urandom_range(TINY_SPAN) - TINY_SPAN / 2;
          sec[s].a1 = $urandom_range(TINY_SPAN) - TINY_SPAN / 2;
          sec[s].a2 = $urandom_range(TINY_SPAN) - TINY_SPAN / 2;
        end
        default:      sec[s] = {$urandom, $urandom, $urandom, $urandom, $urandom};
      endcase
    end
    // upper half of the a2 registers carries junk that must be dropped
    write_reg(REG_SEC0_B0_B1, {sec[0].b1, sec[0].b0});
    write_reg(REG_SEC0_B2_A1, {sec[0].a1, sec[0].b2});
    write_reg(REG_SEC0_A2, {$urandom, sec[0].a2});
    write_reg(REG_SEC1_B0_B1, {sec[1].b1, sec[1].b0});
    write_reg(REG_SEC1_B2_A1, {sec[1].a1, sec[1].b2});
    write_reg(REG_SEC1_A2, {$urandom, sec[1].a2});
    if ($urandom_range(1))
      write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return roll[0] ? SMP_MAX : SMP_MIN;
    if (roll < 30) return SMP_W'($urandom_range(127) - 64);
    return SMP_W'($urandom);
  endfunction

  initial begin
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample_in = '0;
    tag_typed = 1'b0;
    tag_res   = ZERO_RES;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(SCRIPT); i++) begin
      if (SCRIPT[i].kind == ROW_WRITE)
        write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      else
        offer(SCRIPT[i].smp, SCRIPT[i].typed, SCRIPT[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 76;
      end else if (ph < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_setting(PHASE_PLAN[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) offer(pick_sample(), 1'b0, ZERO_RES);
    end

    in_valid <= 1'b0;
    while (outputs_seen != samples_accepted) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
